// ===== sv/fccm_pkg.sv =====
// Shared types and constants for the FAT cluster chain manager.
// No dependencies; imported by every module of the block except fccm_ram.
package fccm_pkg;

  // Table geometry
  localparam int unsigned TABLE_ENTRIES      = 2304;
  localparam int unsigned FIRST_DATA_CLUSTER = 2;
  localparam int unsigned ADDR_W             = $clog2(TABLE_ENTRIES);
  localparam int unsigned SCAN_W             = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned LINK_W             = 16;

  localparam logic [LINK_W-1:0] TABLE_LIMIT    = LINK_W'(TABLE_ENTRIES);
  localparam logic [LINK_W-1:0] LINK_FREE      = 16'h0000;
  localparam logic [LINK_W-1:0] LINK_END       = 16'hFFFF;
  localparam logic [LINK_W-1:0] MAX_LEN_RESET  = 16'd2880;

  // Command codes
  localparam logic [2:0] CMD_LOAD   = 3'd0;
  localparam logic [2:0] CMD_READ   = 3'd1;
  localparam logic [2:0] CMD_ALLOC  = 3'd2;
  localparam logic [2:0] CMD_EXTEND = 3'd3;
  localparam logic [2:0] CMD_FREE   = 3'd4;
  localparam logic [2:0] CMD_WALK   = 3'd5;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFREE  = 2'd1,
    ST_TOOLONG = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  // One result transaction
  typedef struct packed {
    status_e             status;
    logic [LINK_W-1:0]   result_cluster;
    logic [LINK_W-1:0]   chain_count;
  } result_t;

  // Request to the link table memory
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [LINK_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

// ===== sv/fat_cluster_chain_manager.sv =====
// Top level of the FAT cluster chain manager: config register, link table
// memory, command sequencer and output stage. Depends on fccm_pkg,
// fccm_ram, fccm_seq and fccm_out.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  in      | input     | in_valid_i/in_ready_o | cmd_i, cluster_i, link_value_i
//  out     | output    | out_valid_o/out_ready_i| status_o, result_cluster_o, chain_count_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_data_i (max chain length)
//
// One command at a time; the link table is a single RAM with registered read.
// Allocate, and extend of a free or end-of-chain tail, scan for a free entry; the scan
// reads one entry per cycle. Walk and free read each cluster visited, then advance.
// Reset sets max chain length to 2880; the table content is undefined until loaded.
// A stalled output holds one result while the next command runs.
module fat_cluster_chain_manager
  import fccm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        cmd_i,
  input  logic [LINK_W-1:0] cluster_i,
  input  logic [LINK_W-1:0] link_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [LINK_W-1:0] result_cluster_o,
  output logic [LINK_W-1:0] chain_count_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [LINK_W-1:0] cfg_data_i
);

  logic [LINK_W-1:0] max_len_q;
  ram_req_t          ram_req;
  logic [LINK_W-1:0] rd_data;
  logic              res_valid;
  logic              res_ready;
  result_t           res;
  result_t           out_res;

  // Max chain length register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  // Link table
  fccm_ram #(
    .WIDTH (LINK_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rd_data)
  );

  fccm_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .cluster_i    (cluster_i),
    .link_value_i (link_value_i),
    .max_len_i    (max_len_q),
    .ram_o        (ram_req),
    .rd_data_i    (rd_data),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  fccm_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_res)
  );

  assign status_o         = out_res.status;
  assign result_cluster_o = out_res.result_cluster;
  assign chain_count_o    = out_res.chain_count;

endmodule

// ===== sv/fccm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fccm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/fccm_seq.sv =====
// Command sequencer: decodes a command and runs its read-modify-write steps
// on the link table. Depends on fccm_pkg.
module fccm_seq
  import fccm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        cmd_i,
  input  logic [LINK_W-1:0] cluster_i,
  input  logic [LINK_W-1:0] link_value_i,
  input  logic [LINK_W-1:0] max_len_i,
  output ram_req_t          ram_o,
  input  logic [LINK_W-1:0] rd_data_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output result_t           res_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_RDATA = 4'd2;
  localparam logic [3:0] S_EXT   = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_LINK  = 4'd5;
  localparam logic [3:0] S_WCHK  = 4'd6;
  localparam logic [3:0] S_WDAT  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [2:0]        cmd_q, cmd_d;
  logic [LINK_W-1:0] cl_q, cl_d;
  logic [LINK_W-1:0] lv_q, lv_d;
  logic              skip_en_q, skip_en_d;
  logic [SCAN_W-1:0] iss_q, iss_d;
  logic [ADDR_W-1:0] chk_q, chk_d;
  logic              chk_vld_q, chk_vld_d;
  logic [LINK_W-1:0] cur_q, cur_d;
  logic [LINK_W-1:0] cnt_q, cnt_d;
  logic [LINK_W-1:0] last_q, last_d;
  result_t           res_q, res_d;

  logic              in_range;
  logic [ADDR_W-1:0] cl_idx;
  logic              scan_hit;

  assign in_range = cl_q < TABLE_LIMIT;
  assign cl_idx   = cl_q[ADDR_W-1:0];
  assign scan_hit = chk_vld_q && (rd_data_i == LINK_FREE) &&
                    !(skip_en_q && (chk_q == cl_idx));

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  // Next-state and memory request logic
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    cl_d      = cl_q;
    lv_d      = lv_q;
    skip_en_d = skip_en_q;
    iss_d     = iss_q;
    chk_d     = chk_q;
    chk_vld_d = chk_vld_q;
    cur_d     = cur_q;
    cnt_d     = cnt_q;
    last_d    = last_q;
    res_d     = res_q;
    ram_o     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_i;
          cl_d    = cluster_i;
          lv_d    = link_value_i;
          state_d = S_DISP;
        end
      end

      S_DISP: begin
        res_d = '0;
        unique case (cmd_q)
          CMD_LOAD: begin
            if (!in_range) begin
              res_d.status = ST_RANGE;
            end else begin
              ram_o.we    = 1'b1;
              ram_o.waddr = cl_idx;
              ram_o.wdata = lv_q;
            end
            state_d = S_DONE;
          end
          CMD_READ: begin
            if (!in_range) begin
              res_d.status = ST_RANGE;
              state_d      = S_DONE;
            end else begin
              ram_o.re    = 1'b1;
              ram_o.raddr = cl_idx;
              state_d     = S_RDATA;
            end
          end
          CMD_ALLOC: begin
            skip_en_d = 1'b0;
            iss_d     = SCAN_W'(FIRST_DATA_CLUSTER);
            chk_vld_d = 1'b0;
            state_d   = S_SCAN;
          end
          CMD_EXTEND: begin
            if (!in_range) begin
              res_d.status = ST_RANGE;
              state_d      = S_DONE;
            end else begin
              ram_o.re    = 1'b1;
              ram_o.raddr = cl_idx;
              state_d     = S_EXT;
            end
          end
          CMD_FREE, CMD_WALK: begin
            cur_d   = cl_q;
            cnt_d   = '0;
            last_d  = '0;
            state_d = S_WCHK;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      // Return the entry value
      S_RDATA: begin
        res_d.result_cluster = rd_data_i;
        state_d              = S_DONE;
      end

      // Tail link: return it, or start a scan that skips the tail
      S_EXT: begin
        if ((rd_data_i == LINK_FREE) || (rd_data_i == LINK_END)) begin
          skip_en_d = 1'b1;
          iss_d     = SCAN_W'(FIRST_DATA_CLUSTER);
          chk_vld_d = 1'b0;
          state_d   = S_SCAN;
        end else begin
          res_d.result_cluster = rd_data_i;
          state_d              = S_DONE;
        end
      end

      // Pipelined free-entry scan: issue one read, check the previous one
      S_SCAN: begin
        priority if (scan_hit) begin
          ram_o.we             = 1'b1;
          ram_o.waddr          = chk_q;
          ram_o.wdata          = LINK_END;
          res_d.result_cluster = LINK_W'(chk_q);
          state_d              = (cmd_q == CMD_EXTEND) ? S_LINK : S_DONE;
        end else if (iss_q < SCAN_W'(TABLE_ENTRIES)) begin
          ram_o.re    = 1'b1;
          ram_o.raddr = iss_q[ADDR_W-1:0];
          chk_d       = iss_q[ADDR_W-1:0];
          chk_vld_d   = 1'b1;
          iss_d       = iss_q + SCAN_W'(1);
        end else begin
          res_d.status = ST_NOFREE;
          state_d      = S_DONE;
        end
      end

      // Link the tail to the new cluster
      S_LINK: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = cl_idx;
        ram_o.wdata = res_q.result_cluster;
        state_d     = S_DONE;
      end

      // Chain walk: decide whether to follow the current cluster
      S_WCHK: begin
        res_d.result_cluster = last_q;
        res_d.chain_count    = cnt_q;
        priority if ((cur_q == LINK_FREE) || (cur_q == LINK_END)) begin
          res_d.status = ST_OK;
          state_d      = S_DONE;
        end else if (cur_q >= TABLE_LIMIT) begin
          res_d.status = ST_RANGE;
          state_d      = S_DONE;
        end else if (cnt_q >= max_len_i) begin
          res_d.status = ST_TOOLONG;
          state_d      = S_DONE;
        end else begin
          ram_o.re    = 1'b1;
          ram_o.raddr = cur_q[ADDR_W-1:0];
          state_d     = S_WDAT;
        end
      end

      // Advance along the chain; zero the link when freeing
      S_WDAT: begin
        if (cmd_q == CMD_FREE) begin
          ram_o.we    = 1'b1;
          ram_o.waddr = cur_q[ADDR_W-1:0];
          ram_o.wdata = LINK_FREE;
        end
        last_d  = cur_q;
        cnt_d   = cnt_q + LINK_W'(1);
        cur_d   = rd_data_i;
        state_d = S_WCHK;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      chk_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      chk_vld_q <= chk_vld_d;
    end
  end

  // Command and working registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    cl_q      <= cl_d;
    lv_q      <= lv_d;
    skip_en_q <= skip_en_d;
    iss_q     <= iss_d;
    chk_q     <= chk_d;
    cur_q     <= cur_d;
    cnt_q     <= cnt_d;
    last_q    <= last_d;
    res_q     <= res_d;
  end

endmodule

// ===== sv/fccm_out.sv =====
// Output register stage: holds one finished result transaction so the
// sequencer can take the next command. Depends on fccm_pkg.
module fccm_out
  import fccm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  output logic    res_ready_o,
  input  result_t res_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign res_ready_o = !valid_q || out_ready_i;

  // Fill when empty or draining, drop when taken
  always_comb begin
    valid_d = valid_q;
    if (res_valid_i && res_ready_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

// ===== sv/fccm_checker.sv =====
// Port-level checker for the FAT cluster chain manager, bound to the top level.
// Depends on fccm_pkg.
module fccm_checker
  import fccm_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [2:0]        cmd_i,
  input logic [LINK_W-1:0] cluster_i,
  input logic [LINK_W-1:0] link_value_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [1:0]        status_o,
  input logic [LINK_W-1:0] result_cluster_o,
  input logic [LINK_W-1:0] chain_count_o,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o,
  input logic [LINK_W-1:0] cfg_data_i
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(status_o) && $stable(result_cluster_o)
      && $stable(chain_count_o))
    else $error("stalled result changed");

  // One command in flight: no transaction right after an accepted one
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted on back-to-back cycles");

  // A failed allocation reports no cluster and no count
  a_nofree_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_NOFREE) |-> (result_cluster_o == '0)
      && (chain_count_o == '0))
    else $error("no-free result carries data");

  // A range error before any visit reports no cluster
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_RANGE) && (chain_count_o == '0)
      |-> (result_cluster_o == '0))
    else $error("range error with nonzero cluster");

endmodule

bind fat_cluster_chain_manager fccm_checker u_fccm_checker (.*);

// ===== tb/chain_table_checker.sv =====
// Watches the command, result and config channels of the FAT cluster chain manager.
// Predicts every result from a private copy of the link table and compares it.
// Depends on fccm_pkg.
module chain_table_checker
  import fccm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [2:0]        cmd_i,
  input  logic [LINK_W-1:0] cluster_i,
  input  logic [LINK_W-1:0] link_value_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [1:0]        status_i,
  input  logic [LINK_W-1:0] result_cluster_i,
  input  logic [LINK_W-1:0] chain_count_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [LINK_W-1:0] cfg_data_i,
  output int                fail_count_o,
  output int                results_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_LIMIT = 10;

  logic [LINK_W-1:0] link_copy [TABLE_ENTRIES];
  logic [LINK_W-1:0] chain_limit;
  result_t           owed_results [$];
  int                mismatches;

  // Lowest free cluster from the first data cluster up, skipping one entry
  function automatic int unsigned first_free_cluster(input int unsigned skip);
    for (int unsigned i = FIRST_DATA_CLUSTER; i < TABLE_ENTRIES; i++) begin
      if (i != skip && link_copy[i[ADDR_W-1:0]] == LINK_FREE) return i;
    end
    return TABLE_ENTRIES;
  endfunction

  // Follow a chain from its start; optionally zero every link visited
  function automatic result_t follow_links(input logic [LINK_W-1:0] start,
                                           input bit clear_links);
    result_t           r;
    logic [LINK_W-1:0] at;
    logic [LINK_W-1:0] nxt;
    int unsigned       visited;
    r.status         = ST_OK;
    r.result_cluster = '0;
    at               = start;
    visited          = 0;
    while (at != LINK_FREE && at != LINK_END) begin
      if (at >= TABLE_LIMIT) begin
        r.status = ST_RANGE;
        break;
      end
      if (visited >= 32'(chain_limit)) begin
        r.status = ST_TOOLONG;
        break;
      end
      nxt = link_copy[at[ADDR_W-1:0]];
      if (clear_links) link_copy[at[ADDR_W-1:0]] = LINK_FREE;
      r.result_cluster = at;
      visited++;
      at = nxt;
    end
    r.chain_count = LINK_W'(visited);
    return r;
  endfunction

  // Apply one command to the table copy and return its result
  function automatic result_t command_outcome(input logic [2:0] op,
                                              input logic [LINK_W-1:0] cl,
                                              input logic [LINK_W-1:0] lv);
    result_t           r;
    int unsigned       spot;
    logic [LINK_W-1:0] nxt;
    r.status         = ST_OK;
    r.result_cluster = '0;
    r.chain_count    = '0;
    case (op)
      CMD_LOAD: begin
        if (cl >= TABLE_LIMIT) r.status = ST_RANGE;
        else link_copy[cl[ADDR_W-1:0]] = lv;
      end
      CMD_READ: begin
        if (cl >= TABLE_LIMIT) r.status = ST_RANGE;
        else r.result_cluster = link_copy[cl[ADDR_W-1:0]];
      end
      CMD_ALLOC: begin
        spot = first_free_cluster(TABLE_ENTRIES);
        if (spot >= TABLE_ENTRIES) begin
          r.status = ST_NOFREE;
        end else begin
          link_copy[spot[ADDR_W-1:0]] = LINK_END;
          r.result_cluster            = LINK_W'(spot);
        end
      end
      CMD_EXTEND: begin
        if (cl >= TABLE_LIMIT) begin
          r.status = ST_RANGE;
        end else begin
          nxt = link_copy[cl[ADDR_W-1:0]];
          if (nxt == LINK_FREE || nxt == LINK_END) begin
            // tail has no successor: link a fresh cluster, never the tail itself
            spot = first_free_cluster(32'(cl));
            if (spot >= TABLE_ENTRIES) begin
              r.status = ST_NOFREE;
            end else begin
              link_copy[cl[ADDR_W-1:0]]   = LINK_W'(spot);
              link_copy[spot[ADDR_W-1:0]] = LINK_END;
              r.result_cluster            = LINK_W'(spot);
            end
          end else begin
            r.result_cluster = nxt;
          end
        end
      end
      CMD_FREE: r = follow_links(cl, 1'b1);
      CMD_WALK: r = follow_links(cl, 1'b0);
      default: ;
    endcase
    return r;
  endfunction

  // Track config, predict on command transactions, compare on result transactions
  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      chain_limit = MAX_LEN_RESET;
      owed_results.delete();
      mismatches = 0;
      fail_count_o   <= 0;
      results_owed_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) chain_limit = cfg_data_i;
      if (in_valid_i && in_ready_i)
        owed_results.push_back(command_outcome(cmd_i, cluster_i, link_value_i));
      if (out_valid_i && out_ready_i) begin
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result: status %0d cluster %0d count %0d",
                     status_i, result_cluster_i, chain_count_i);
        end else begin
          want = owed_results.pop_front();
          if (status_i != want.status || result_cluster_i != want.result_cluster ||
              chain_count_i != want.chain_count) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("mismatch: expected status %0d cluster %0d count %0d, got %0d %0d %0d",
                       want.status, want.result_cluster, want.chain_count,
                       status_i, result_cluster_i, chain_count_i);
          end
        end
      end
      fail_count_o   <= mismatches;
      results_owed_o <= owed_results.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the FAT cluster chain manager testbench: clock, reset, command and
// config stimulus, result backpressure and the verdict.
// Depends on fccm_pkg, fat_cluster_chain_manager and chain_table_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fccm_pkg::*;

  localparam logic [2:0]  CMD_SPARE_A   = 3'd6;
  localparam logic [2:0]  CMD_SPARE_B   = 3'd7;
  // Timeout well above the slowest legal run (walks at the chain limit, the
  // longest limit on a loop, worst stalls on both sides).
  localparam int unsigned LIMIT_CYCLES  = 2_000_000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned PHASE_ITEMS   = 26;
  localparam int unsigned CALM_ITEMS    = 12;
  // random chains live in this small window of the table
  localparam int unsigned SMALL_SPAN    = 47;
  // entries up to here are loaded before use; those above the random span
  // are claimed only by allocate and extend, so a scan always stops inside
  localparam int unsigned WINDOW_TOP    = 79;
  localparam int unsigned GRAB_BUDGET   = WINDOW_TOP - SMALL_SPAN - 1;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [2:0]        cmd_i;
  logic [LINK_W-1:0] cluster_i;
  logic [LINK_W-1:0] link_value_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [1:0]        status_o;
  logic [LINK_W-1:0] result_cluster_o;
  logic [LINK_W-1:0] chain_count_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [LINK_W-1:0] cfg_data_i;

  int          fail_count;
  int          results_owed;
  bit          calm;
  int          stall_requests;
  int          stall_served;
  int unsigned sent;
  int unsigned grabs;
  int unsigned cycle_count = 0;

  fat_cluster_chain_manager uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .cluster_i        (cluster_i),
    .link_value_i     (link_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .result_cluster_o (result_cluster_o),
    .chain_count_o    (chain_count_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  chain_table_checker chain_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .cmd_i            (cmd_i),
    .cluster_i        (cluster_i),
    .link_value_i     (link_value_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_i         (status_o),
    .result_cluster_i (result_cluster_o),
    .chain_count_i    (chain_count_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .fail_count_o     (fail_count),
    .results_owed_o   (results_owed)
  );

  // 100 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result backpressure: one long hold on request, else short random bursts
  initial begin
    out_ready_i  <= 1'b0;
    stall_served = 0;
    forever begin
      @(posedge clk_i);
      if (stall_requests > stall_served) begin
        stall_served++;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Offer one command transaction, with an occasional idle burst ahead of it
  task automatic issue(input logic [2:0] op, input logic [LINK_W-1:0] cl,
                       input logic [LINK_W-1:0] lv);
    // keep a free cluster inside the loaded window: walk once the budget is spent
    if ((op == CMD_ALLOC || op == CMD_EXTEND) && grabs >= GRAB_BUDGET) op = CMD_WALK;
    if (op == CMD_ALLOC || op == CMD_EXTEND) grabs++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= op;
    cluster_i    <= cl;
    link_value_i <= lv;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  // Write the chain length limit once the block has drained
  task automatic set_max_len(input logic [LINK_W-1:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_owed != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Load a range of entries with free links
  task automatic fill_table(input int unsigned lo, input int unsigned hi);
    for (int unsigned i = lo; i <= hi; i++)
      issue(CMD_LOAD, LINK_W'(i), LINK_FREE);
  endtask

  // Links stay inside the random span or point past the table
  function automatic logic [LINK_W-1:0] pick_link();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) return LINK_W'($urandom_range(FIRST_DATA_CLUSTER, SMALL_SPAN));
    if (p < 55) return LINK_END;
    if (p < 70) return LINK_FREE;
    if (p < 80) return LINK_W'($urandom_range(TABLE_ENTRIES, 16'hFFFE));
    return LINK_W'($urandom_range(0, SMALL_SPAN));
  endfunction

  // One command of any kind with loosely shaped fields
  task automatic random_item();
    logic [2:0]        op;
    logic [LINK_W-1:0] cl;
    int unsigned       p;
    p  = $urandom_range(0, 99);
    op = p < 25 ? CMD_LOAD : p < 35 ? CMD_READ : p < 50 ? CMD_ALLOC :
         p < 70 ? CMD_EXTEND : p < 80 ? CMD_FREE : p < 95 ? CMD_WALK :
         ($urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B);
    p = $urandom_range(0, 99);
    if (p < 75)      cl = LINK_W'($urandom_range(0, SMALL_SPAN));
    else if (p < 85) cl = LINK_W'($urandom_range(TABLE_ENTRIES - 1, TABLE_ENTRIES + 3));
    else             cl = LINK_W'($urandom_range(TABLE_ENTRIES, 16'hFFFF));
    issue(op, cl, pick_link());
  endtask

  // Build a short chain by loads, walk it, then extend it, free it or leave it
  task automatic random_chain();
    int unsigned       len;
    int unsigned       base;
    int unsigned       p;
    logic [LINK_W-1:0] tail_link;
    len  = $urandom_range(1, 6);
    base = $urandom_range(FIRST_DATA_CLUSTER, SMALL_SPAN - len);
    for (int unsigned k = 0; k + 1 < len; k++)
      issue(CMD_LOAD, LINK_W'(base + k), LINK_W'(base + k + 1));
    p = $urandom_range(0, 99);
    if (p < 20)      tail_link = LINK_W'(base);
    else if (p < 80) tail_link = LINK_END;
    else             tail_link = pick_link();
    issue(CMD_LOAD, LINK_W'(base + len - 1), tail_link);
    issue(CMD_WALK, LINK_W'(base), LINK_W'($urandom()));
    p = $urandom_range(0, 99);
    if (p < 50) begin
      issue(CMD_EXTEND, LINK_W'(base + len - 1), LINK_W'($urandom()));
      issue(CMD_WALK, LINK_W'(base), LINK_W'($urandom()));
    end else if (p < 80) begin
      issue(CMD_FREE, LINK_W'(base), LINK_W'($urandom()));
      issue(CMD_READ, LINK_W'(base), LINK_W'($urandom()));
    end
  endtask

  // Random traffic under one chain length limit
  task automatic random_phase(input logic [LINK_W-1:0] max_len, input bit squeeze,
                              input bit calm_end);
    int unsigned goal;
    set_max_len(max_len);
    goal = sent + PHASE_ITEMS;
    // hold the result side while commands keep coming, so the input stalls
    if (squeeze) begin
      stall_requests <= stall_requests + 1;
      repeat (12) issue($urandom_range(0, 1) ? CMD_LOAD : CMD_READ,
                        LINK_W'($urandom_range(0, SMALL_SPAN)), pick_link());
    end
    while (sent < goal) begin
      if (calm_end && goal - sent <= CALM_ITEMS) calm <= 1'b1;
      if ($urandom_range(0, 1)) random_chain();
      else random_item();
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    cmd_i          <= CMD_LOAD;
    cluster_i      <= '0;
    link_value_i   <= '0;
    cfg_valid_i    <= 1'b0;
    cfg_data_i     <= '0;
    calm           <= 1'b0;
    stall_requests <= 0;
    sent  = 0;
    grabs = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Define the working window before anything reads the table
    fill_table(0, WINDOW_TOP);

    // Index out of range on load, read and extend
    issue(CMD_READ, TABLE_LIMIT, LINK_FREE);
    issue(CMD_READ, LINK_END, LINK_END);
    issue(CMD_LOAD, LINK_END, 16'h1234);
    issue(CMD_EXTEND, TABLE_LIMIT, LINK_FREE);
    // Allocate, extend from an end-of-chain tail, then from a linked one
    issue(CMD_ALLOC, LINK_FREE, LINK_FREE);
    issue(CMD_EXTEND, 16'd2, LINK_FREE);
    issue(CMD_EXTEND, 16'd2, LINK_FREE);
    issue(CMD_EXTEND, 16'd40, LINK_FREE);
    issue(CMD_WALK, 16'd2, LINK_FREE);
    // Chains that start at a terminator or out of range
    issue(CMD_WALK, LINK_FREE, LINK_FREE);
    issue(CMD_WALK, LINK_END, LINK_FREE);
    issue(CMD_FREE, 16'd5000, LINK_FREE);
    // Link out of range in the middle of a chain
    issue(CMD_LOAD, 16'd10, 16'd3000);
    issue(CMD_WALK, 16'd10, LINK_FREE);
    issue(CMD_FREE, 16'd10, LINK_FREE);
    // Two-cluster loop trips the length limit
    issue(CMD_LOAD, 16'd20, 16'd21);
    issue(CMD_LOAD, 16'd21, 16'd20);
    issue(CMD_WALK, 16'd20, LINK_FREE);
    issue(CMD_FREE, 16'd2, LINK_FREE);
    issue(CMD_READ, 16'd3, LINK_FREE);
    issue(CMD_LOAD, LINK_W'(TABLE_ENTRIES - 1), LINK_END);
    issue(CMD_READ, LINK_W'(TABLE_ENTRIES - 1), LINK_FREE);
    issue(CMD_SPARE_A, LINK_END, LINK_END);
    issue(CMD_SPARE_B, LINK_FREE, 16'hAAAA);

    // Longest limit on the loop, then the shortest on a real chain
    set_max_len(16'hFFFF);
    issue(CMD_WALK, 16'd20, LINK_FREE);
    issue(CMD_FREE, 16'd20, LINK_FREE);
    set_max_len(16'd1);
    issue(CMD_LOAD, 16'd30, 16'd31);
    issue(CMD_LOAD, 16'd31, LINK_END);
    issue(CMD_WALK, 16'd30, LINK_FREE);
    issue(CMD_FREE, 16'd30, LINK_FREE);

    // Random traffic across several limits
    random_phase(16'd3, 1'b1, 1'b0);
    random_phase(16'd1, 1'b0, 1'b0);
    random_phase(16'd40, 1'b0, 1'b0);
    random_phase(LINK_W'($urandom_range(4, 300)), 1'b0, 1'b0);
    random_phase(MAX_LEN_RESET, 1'b0, 1'b1);

    // Drain and decide
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_owed != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
